// ===== rtl/lfulru_pkg.sv =====
// lfulru_pkg: shared types and constants of the lfu replacement block with lru tie-break
// fixed field widths, command codes, controller states and the ctrl/datapath structs
// depends on nothing
package lfulru_pkg;

  localparam int unsigned CMD_W     = 2;
  localparam int unsigned SET_IN_W  = 11;
  localparam int unsigned WAY_IN_W  = 4;
  localparam int unsigned VICTIM_W  = 4;
  localparam int unsigned STAMP_W   = 64;

  localparam logic [CMD_W-1:0] CMD_VICTIM = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FILL   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ACCESS = 2'd2;

  // reciprocal used for the set modulo
  localparam int unsigned MOD_SH    = 22;
  localparam int unsigned RECIP_W   = MOD_SH + 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REM,
    ST_READ,
    ST_EXEC,
    ST_SCAN,
    ST_DONE
  } lfulru_state_t;

  typedef struct packed {
    logic capture;
    logic calc_rem;
    logic mem_rd;
    logic touch_wr;
    logic clr_wr;
    logic scan_init;
    logic scan_step;
    logic out_load;
  } lfulru_cmd_t;

  typedef struct packed {
    logic in_victim;
    logic in_touch;
    logic is_victim;
    logic clr_last;
    logic scan_last;
    logic out_free;
  } lfulru_stat_t;

endpackage

// ===== rtl/lfulru_in_if.sv =====
// lfulru_in_if: request channel, valid/ready with the request fields
// depends on lfulru_pkg
interface lfulru_in_if
  import lfulru_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [SET_IN_W-1:0] set_index;
  logic [WAY_IN_W-1:0] way_index;
  logic                hit_flag;
  logic                is_write;

  modport source (output valid, cmd, set_index, way_index, hit_flag, is_write, input ready);
  modport sink   (input valid, cmd, set_index, way_index, hit_flag, is_write, output ready);
endinterface

// ===== rtl/lfulru_out_if.sv =====
// lfulru_out_if: victim result channel, valid/ready with the chosen way
// depends on lfulru_pkg
interface lfulru_out_if
  import lfulru_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [VICTIM_W-1:0] victim_way;

  modport source (output valid, victim_way, input ready);
  modport sink   (input valid, victim_way, output ready);
endinterface

// ===== rtl/lfu_lru_tiebreak_replacement.sv =====
// lfu_lru_tiebreak_replacement: top level, lfu victim choice with lru and lowest-way tie-break
// joins lfulru_ctrl and lfulru_dp; depends on lfulru_pkg, lfulru_in_if, lfulru_out_if
//
//   port     dir   handshake      carries
//   in_if    sink  valid/ready    cmd, set_index, way_index, hit_flag, is_write
//   out_if   src   valid/ready    victim_way (one item per find-victim request)
//
// fill or counted access: modulo, row read and write back, then the next accept
// find victim: modulo and row read, then the one-way-a-cycle scan of the registered set row
// other items are taken and change nothing
// after reset a clearing pass over every set zeroes the row memory; no item is taken meanwhile
// a stalled result sits in the output register; a further victim request waits for it to drain
module lfu_lru_tiebreak_replacement
  import lfulru_pkg::*;
#(
  parameter int unsigned SETS        = 2048,
  parameter int unsigned WAYS        = 16,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input logic          clk,
  input logic          rst_n,
  lfulru_in_if.sink    in_if,
  lfulru_out_if.source out_if
);

  lfulru_cmd_t  cmd;
  lfulru_stat_t stat;
  logic         in_ready;

  assign in_if.ready = in_ready;

  lfulru_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lfulru_dp #(
    .SETS        (SETS),
    .WAYS        (WAYS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_cmd         (in_if.cmd),
    .in_set_index   (in_if.set_index),
    .in_way_index   (in_if.way_index),
    .in_hit_flag    (in_if.hit_flag),
    .in_is_write    (in_if.is_write),
    .out_valid      (out_if.valid),
    .out_ready      (out_if.ready),
    .out_victim_way (out_if.victim_way),
    .cmd            (cmd),
    .stat           (stat)
  );

endmodule

// ===== rtl/lfulru_dp.sv =====
// lfulru_dp: datapath - set row memory, set modulo, way scan, row update, event counter
// and the output register; driven by lfulru_ctrl through lfulru_cmd_t
// depends on lfulru_pkg
module lfulru_dp
  import lfulru_pkg::*;
#(
  parameter int unsigned SETS        = 2048,
  parameter int unsigned WAYS        = 16,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [SET_IN_W-1:0] in_set_index,
  input  logic [WAY_IN_W-1:0] in_way_index,
  input  logic                in_hit_flag,
  input  logic                in_is_write,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [VICTIM_W-1:0] out_victim_way,
  input  lfulru_cmd_t         cmd,
  output lfulru_stat_t        stat
);

  localparam int unsigned SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WAY_W  = $clog2(WAYS);
  localparam int unsigned ENT_W  = COUNT_WIDTH + STAMP_W;
  localparam int unsigned ROW_W  = WAYS * ENT_W;
  localparam int unsigned PROD_W = SET_IN_W + RECIP_W;
  localparam int unsigned REM_W  = SET_IN_W + 18;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << MOD_SH) / SETS);

  logic [ROW_W-1:0]    mem [SETS];
  logic [ROW_W-1:0]    rd_row_r;
  logic [ROW_W-1:0]    touch_row;

  logic [SET_IN_W-1:0] set_r;
  logic [SET_IN_W-1:0] q_r;
  logic [SET_W-1:0]    addr_r;
  logic [SET_W-1:0]    clr_addr_r;
  logic [WAY_W-1:0]    way_r;
  logic                is_victim_r;
  logic [STAMP_W-1:0]  event_r;

  logic [WAY_W-1:0]    scan_r;
  logic [WAY_W-1:0]    best_r;
  logic [ENT_W-1:0]    best_key_r;
  logic [ENT_W-1:0]    cand;

  logic                out_valid_r;
  logic [VICTIM_W-1:0] victim_r;

  logic [PROD_W-1:0]   prod;
  logic [REM_W-1:0]    rem_raw;
  logic [REM_W-1:0]    rem_fix;
  logic                way_ok;

  logic [ENT_W-1:0]       old_ent;
  logic [COUNT_WIDTH-1:0] old_cnt;
  logic [COUNT_WIDTH-1:0] new_cnt;

  // request decode
  assign way_ok = 32'(in_way_index) < WAYS;
  assign stat.in_victim = (in_cmd == CMD_VICTIM);
  assign stat.in_touch  = way_ok && ((in_cmd == CMD_FILL) ||
                          ((in_cmd == CMD_ACCESS) && in_hit_flag && !in_is_write));
  assign stat.is_victim = is_victim_r;
  assign stat.clr_last  = (clr_addr_r == SET_W'(SETS - 1));
  assign stat.scan_last = (scan_r == WAY_W'(WAYS - 1));
  assign stat.out_free  = !out_valid_r || out_ready;

  // set modulo: quotient estimate low by at most one, then one correction
  assign prod    = PROD_W'(in_set_index) * PROD_W'(RECIP);
  assign rem_raw = REM_W'(set_r) - REM_W'(q_r) * REM_W'(SETS);
  assign rem_fix = (rem_raw >= REM_W'(SETS)) ? (rem_raw - REM_W'(SETS)) : rem_raw;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      set_r       <= in_set_index;
      q_r         <= SET_IN_W'(prod >> MOD_SH);
      way_r       <= WAY_W'(in_way_index);
      is_victim_r <= stat.in_victim;
    end
    if (cmd.calc_rem) begin
      addr_r <= SET_W'(rem_fix);
    end
  end

  // row memory
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[clr_addr_r] <= '0;
    end else if (cmd.touch_wr) begin
      mem[addr_r] <= touch_row;
    end
    if (cmd.mem_rd) begin
      rd_row_r <= mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr_r <= clr_addr_r + SET_W'(1);
    end
  end

  // touched way: saturating count and fresh stamp
  assign old_ent = rd_row_r[way_r*ENT_W +: ENT_W];
  assign old_cnt = old_ent[ENT_W-1 -: COUNT_WIDTH];
  assign new_cnt = (old_cnt == '1) ? old_cnt : (old_cnt + COUNT_WIDTH'(1));

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      if (WAY_W'(w) == way_r) begin
        touch_row[w*ENT_W +: ENT_W] = {new_cnt, event_r};
      end else begin
        touch_row[w*ENT_W +: ENT_W] = rd_row_r[w*ENT_W +: ENT_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      event_r <= '0;
    end else if (cmd.touch_wr) begin
      event_r <= event_r + STAMP_W'(1);
    end
  end

  // victim scan, one way a cycle; key is {count, stamp}
  assign cand = rd_row_r[scan_r*ENT_W +: ENT_W];

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      best_r     <= '0;
      best_key_r <= rd_row_r[ENT_W-1:0];
      scan_r     <= WAY_W'(1);
    end else if (cmd.scan_step) begin
      if (cand < best_key_r) begin
        best_r     <= scan_r;
        best_key_r <= cand;
      end
      scan_r <= scan_r + WAY_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      victim_r <= VICTIM_W'(best_r);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_victim_way = victim_r;

endmodule

// ===== rtl/lfulru_ctrl.sv =====
// lfulru_ctrl: controller state machine - clearing pass, request sequencing, way scan
// issues lfulru_cmd_t to lfulru_dp and reads back lfulru_stat_t
// depends on lfulru_pkg
module lfulru_ctrl
  import lfulru_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  lfulru_stat_t stat,
  output lfulru_cmd_t  cmd
);

  lfulru_state_t state_r;
  lfulru_state_t state_nxt;
  logic          accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && (stat.in_victim || stat.in_touch)) state_nxt = ST_REM;
      end
      ST_REM:  state_nxt = ST_READ;
      ST_READ: state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = stat.is_victim ? ST_SCAN : ST_IDLE;
      ST_SCAN: begin
        if (stat.scan_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_CLEAR: cmd.clr_wr = 1'b1;
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_REM:  cmd.calc_rem = 1'b1;
      ST_READ: cmd.mem_rd   = 1'b1;
      ST_EXEC: begin
        cmd.scan_init = stat.is_victim;
        cmd.touch_wr  = !stat.is_victim;
      end
      ST_SCAN: cmd.scan_step = 1'b1;
      ST_DONE: cmd.out_load  = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule
